/* rtl/slwf_pkg.sv */
// slwf_pkg: shared constants and types for the stack low-water finder.
// No dependencies; used by stack_low_water_finder and slwf_ram users.

package slwf_pkg;

   // default store geometry
   localparam int DEPTH_DEF = 8192;
   localparam int BLOCK_DEF = 32;

   // field widths fixed by the item format
   localparam int ADDR_W = 13;
   localparam int BYTE_W = 8;
   localparam int OLD_W  = 15;
   localparam int MARK_W = 14;

   // byte positions during a search, wide enough for any mark plus a scan past the store
   localparam int POS_W = 17;

   localparam logic [BYTE_W-1:0] PAINT = 8'hFF;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_QUERY = 1'b1
   } opcode_type;

   typedef enum logic [5:0] {
      ST_CLEAR  = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_PROBE  = 6'b000100,
      ST_DECIDE = 6'b001000,
      ST_SCAN   = 6'b010000,
      ST_DONE   = 6'b100000
   } state_type;

endpackage

/* rtl/slwf_ram.sv */
// slwf_ram: generic single-write, single-read synchronous RAM, registered read.
// No dependencies.

module slwf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/stack_low_water_finder.sv */
// stack_low_water_finder: painted-stack byte store with a low-water mark search.
// Depends on slwf_pkg and slwf_ram.
//
//   channel | dir | handshake            | payload
//   req     | in  | req_valid/req_stall  | opcode, byte_address, byte_value, old_mark
//   rsp     | out | rsp_valid/rsp_stall  | new_mark, blown
//
// A write item is written to the store when it is taken. A query reads the
// byte store one byte a cycle, in block probes and a final scan; the store has
// one write and one read port. Probes is two plus about log2(old_mark / BLOCK).
// After reset the store is painted 0xFF one byte a cycle, all DEPTH bytes, with
// req_stall high. A result waits in the output register while the next item
// is taken; a query that finishes while that register is full holds there.

module stack_low_water_finder #(
   parameter int DEPTH = slwf_pkg::DEPTH_DEF,
   parameter int BLOCK = slwf_pkg::BLOCK_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_opcode,
   input  logic [slwf_pkg::ADDR_W-1:0]  req_byte_address,
   input  logic [slwf_pkg::BYTE_W-1:0]  req_byte_value,
   input  logic signed [slwf_pkg::OLD_W-1:0] req_old_mark,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [slwf_pkg::MARK_W-1:0]  rsp_new_mark,
   output logic                         rsp_blown
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(2 * BLOCK + 1);
   localparam int PW = slwf_pkg::POS_W;
   localparam logic [CW-1:0] LEN_PROBE = CW'(BLOCK);
   localparam logic [CW-1:0] LEN_SCAN  = CW'(2 * BLOCK);
   localparam logic [PW-1:0] DEPTH_POS = PW'(DEPTH);
   localparam logic [PW-1:0] BLOCK_POS = PW'(BLOCK);

   slwf_pkg::state_type state_ff, state_in;

   logic [AW-1:0]               clr_ff, clr_in;
   logic [PW-1:0]               base_ff, base_in;
   logic [PW-1:0]               lo_ff, lo_in;
   logic [PW-1:0]               hi_ff, hi_in;
   logic                        first_ff, first_in;
   logic [CW-1:0]               iss_ff, iss_in;
   logic [CW-1:0]               chk_ff, chk_in;
   logic                        pend_ff, pend_in;
   logic                        pend_oor_ff, pend_oor_in;
   logic [slwf_pkg::MARK_W-1:0] mark_ff, mark_in;
   logic [slwf_pkg::MARK_W-1:0] res_ff, res_in;
   logic                        res_blown_ff, res_blown_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [slwf_pkg::MARK_W-1:0] rsp_mark_ff, rsp_mark_in;
   logic                        rsp_blown_ff, rsp_blown_in;

   logic                        req_take;
   logic [PW-1:0]               wr_pos;
   logic [PW-1:0]               mark_pos;
   logic                        wr_en;
   logic [AW-1:0]               wr_addr;
   logic [slwf_pkg::BYTE_W-1:0] wr_data;
   logic                        rd_en;
   logic [slwf_pkg::BYTE_W-1:0] rd_data;
   logic                        walking;
   logic [CW-1:0]               len;
   logic [PW-1:0]               pos;
   logic                        fail;
   logic                        pass;
   logic                        finish;
   logic [PW-1:0]               mid;
   logic                        keep_going;
   logic                        load_rsp;

   function automatic logic [slwf_pkg::MARK_W-1:0] MARK_W_TRUNC(input logic [PW-1:0] value);
      MARK_W_TRUNC = value[slwf_pkg::MARK_W-1:0];
   endfunction

   assign req_stall = (state_ff != slwf_pkg::ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign wr_pos    = PW'(req_byte_address);
   assign mark_pos  = PW'(req_old_mark[slwf_pkg::OLD_W-2:0]);

   // byte read engine shared by block probes and the final scan
   assign walking = (state_ff == slwf_pkg::ST_PROBE) || (state_ff == slwf_pkg::ST_SCAN);
   assign len     = (state_ff == slwf_pkg::ST_SCAN) ? LEN_SCAN : LEN_PROBE;
   assign pos     = base_ff + PW'(iss_ff);
   assign rd_en   = walking && (iss_ff != len);
   assign fail    = pend_ff && (pend_oor_ff || (rd_data != slwf_pkg::PAINT));
   assign pass    = pend_ff && !fail && (chk_ff == len - CW'(1));
   assign finish  = fail || pass;

   assign mid        = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign keep_going = (lo_ff + BLOCK_POS) <= hi_ff;
   assign load_rsp   = (state_ff == slwf_pkg::ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = wr_pos[AW-1:0];
      wr_data = req_byte_value;
      if (state_ff == slwf_pkg::ST_CLEAR) begin
         wr_en   = 1'b1;
         wr_addr = clr_ff;
         wr_data = slwf_pkg::PAINT;
      end else if (req_take && (req_opcode == slwf_pkg::OP_WRITE) && (wr_pos < DEPTH_POS)) begin
         wr_en = 1'b1;
      end
   end

   slwf_ram #(
      .WIDTH (slwf_pkg::BYTE_W),
      .DEPTH (DEPTH)
   ) u_bytes (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (pos[AW-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      base_in      = base_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      first_in     = first_ff;
      mark_in      = mark_ff;
      res_in       = res_ff;
      res_blown_in = res_blown_ff;

      // a finished probe or scan drops the read still in flight
      pend_in     = rd_en && !finish;
      pend_oor_in = pos >= DEPTH_POS;
      iss_in      = finish ? '0 : (rd_en ? iss_ff + CW'(1) : iss_ff);
      chk_in      = finish ? '0 : (pend_ff ? chk_ff + CW'(1) : chk_ff);

      unique case (state_ff)
         slwf_pkg::ST_CLEAR: begin
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = slwf_pkg::ST_IDLE;
            end
         end
         slwf_pkg::ST_IDLE: begin
            if (req_take && (req_opcode == slwf_pkg::OP_QUERY)) begin
               mark_in      = req_old_mark[slwf_pkg::MARK_W-1:0];
               lo_in        = '0;
               res_blown_in = 1'b0;
               first_in     = 1'b1;
               if (req_old_mark[slwf_pkg::OLD_W-1]) begin
                  res_in       = '0;
                  res_blown_in = 1'b1;
                  state_in     = slwf_pkg::ST_DONE;
               end else if (mark_pos > BLOCK_POS) begin
                  base_in  = mark_pos - BLOCK_POS;
                  state_in = slwf_pkg::ST_PROBE;
               end else begin
                  base_in  = '0;
                  state_in = slwf_pkg::ST_SCAN;
               end
            end
         end
         slwf_pkg::ST_PROBE: begin
            if (finish) begin
               if (first_ff) begin
                  if (pass) begin
                     res_in   = mark_ff;
                     state_in = slwf_pkg::ST_DONE;
                  end else begin
                     hi_in    = base_ff;
                     state_in = slwf_pkg::ST_DECIDE;
                  end
               end else begin
                  if (pass) begin
                     lo_in = base_ff;
                  end else begin
                     hi_in = base_ff;
                  end
                  state_in = slwf_pkg::ST_DECIDE;
               end
            end
         end
         slwf_pkg::ST_DECIDE: begin
            // the search always probes at least once after the mark block fails
            if (first_ff || keep_going) begin
               base_in  = mid;
               first_in = 1'b0;
               state_in = slwf_pkg::ST_PROBE;
            end else begin
               base_in  = lo_ff;
               state_in = slwf_pkg::ST_SCAN;
            end
         end
         slwf_pkg::ST_SCAN: begin
            if (finish) begin
               res_in   = MARK_W_TRUNC(base_ff + PW'(chk_ff) + PW'(pass));
               state_in = slwf_pkg::ST_DONE;
            end
         end
         slwf_pkg::ST_DONE: begin
            if (load_rsp) begin
               state_in = slwf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = slwf_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = (rsp_valid_ff && rsp_stall) || load_rsp;
      rsp_mark_in  = load_rsp ? res_ff : rsp_mark_ff;
      rsp_blown_in = load_rsp ? res_blown_ff : rsp_blown_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= slwf_pkg::ST_CLEAR;
         clr_ff       <= '0;
         iss_ff       <= '0;
         chk_ff       <= '0;
         pend_ff      <= 1'b0;
         first_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         iss_ff       <= iss_in;
         chk_ff       <= chk_in;
         pend_ff      <= pend_in;
         first_ff     <= first_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff      <= base_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      pend_oor_ff  <= pend_oor_in;
      mark_ff      <= mark_in;
      res_ff       <= res_in;
      res_blown_ff <= res_blown_in;
      rsp_mark_ff  <= rsp_mark_in;
      rsp_blown_ff <= rsp_blown_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_new_mark = rsp_mark_ff;
   assign rsp_blown    = rsp_blown_ff;

endmodule
